@@ src/lzwd_pkg.sv @@
// lzwd_pkg: shared constants, field widths and controller/datapath interface types
// for the lzw code stream decoder; no dependencies
package lzwd_pkg;

	localparam int BASE_CODES         = 256;
	localparam int DICT_SIZE_DEF      = 4096;
	localparam int MAX_STRING_LEN_DEF = 64;

	localparam int CODE_WORD_W  = 16;
	localparam int BYTE_W       = 8;
	localparam int DICT_LIMIT_W = 13;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register indexes (byte address = 4 * index)
	localparam logic [APB_ADDR_W-3:0] REG_DICT_LIMIT = 1'b0;

	localparam logic [DICT_LIMIT_W-1:0] DICT_LIMIT_RESET = 13'd4096;

	typedef struct packed {
		logic accept;
		logic begin_walk;
		logic push_tail;
		logic push_root;
		logic stack_rd;
		logic load_byte;
		logic load_err;
	} lzwd_cmd_t;

	typedef struct packed {
		logic halted;
		logic known;
		logic kwk;
		logic wc_root;
		logic prefix_root;
		logic room;
		logic pop_last;
		logic out_free;
	} lzwd_status_t;

endpackage

@@ src/lzwd_cfg.sv @@
// lzwd_cfg: apb-style register port holding the dictionary limit
// depends on lzwd_pkg
module lzwd_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lzwd_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lzwd_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lzwd_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	output logic [lzwd_pkg::DICT_LIMIT_W-1:0] dict_limit
);
	import lzwd_pkg::*;

	logic [DICT_LIMIT_W-1:0] dict_limit_q;
	logic                    sel_limit;

	assign pready     = 1'b1;
	assign sel_limit  = (paddr[APB_ADDR_W-1:2] == REG_DICT_LIMIT);
	assign dict_limit = dict_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dict_limit_q <= DICT_LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && sel_limit) begin
			dict_limit_q <= pwdata[DICT_LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_limit) begin
			prdata = APB_DATA_W'(dict_limit_q);
		end
	end

endmodule

@@ src/lzwd_datapath.sv @@
// lzwd_datapath: dictionary memory, reverse stack, stream state and output register
// depends on lzwd_pkg; driven by lzwd_ctrl commands
module lzwd_datapath #(
	parameter int DICT_SIZE      = lzwd_pkg::DICT_SIZE_DEF,
	parameter int MAX_STRING_LEN = lzwd_pkg::MAX_STRING_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lzwd_pkg::lzwd_cmd_t               cmd,
	output lzwd_pkg::lzwd_status_t            status,
	input  logic [lzwd_pkg::DICT_LIMIT_W-1:0] dict_limit,
	input  logic [lzwd_pkg::CODE_WORD_W-1:0]  code_word,
	input  logic                              stream_start,
	output logic                              byte_valid,
	input  logic                              byte_ready,
	output logic [lzwd_pkg::BYTE_W-1:0]       data_byte,
	output logic                              last_byte,
	output logic                              decode_error
);
	import lzwd_pkg::*;

	localparam int CW    = $clog2(DICT_SIZE);
	localparam int NW    = $clog2(DICT_SIZE + 1);
	localparam int CMPW  = (NW > CODE_WORD_W) ? NW : CODE_WORD_W;
	localparam int DEPTH = DICT_SIZE - BASE_CODES;
	localparam int AW    = $clog2(DEPTH);
	localparam int IW    = $clog2(MAX_STRING_LEN);
	localparam int NCW   = $clog2(MAX_STRING_LEN + 1);

	typedef struct packed {
		logic [CW-1:0]     prefix;
		logic [BYTE_W-1:0] tail;
	} entry_t;

	entry_t            dict_mem [DEPTH];
	logic [BYTE_W-1:0] stack_mem [MAX_STRING_LEN];

	logic [CODE_WORD_W-1:0] code_q;
	logic                   halted_q;
	logic                   have_prev_q;
	logic [CW-1:0]          prev_q;
	logic [NW-1:0]          nfi_q;
	logic                   kwk_q;
	logic [NCW-1:0]         n_q;
	logic [IW-1:0]          p_q;
	logic [BYTE_W-1:0]      root_q;
	logic [CW-1:0]          rd_prefix_q;
	logic [BYTE_W-1:0]      rd_tail_q;
	logic [BYTE_W-1:0]      stk_q;
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_last_q;
	logic                   out_err_q;

	logic [CMPW-1:0] code_ext;
	logic [CMPW-1:0] nfi_ext;
	logic [CMPW-1:0] lim_raw;
	logic [CMPW-1:0] limit;
	logic            known;
	logic            kwk;
	logic            grow;
	logic [CW-1:0]   wc;
	logic            wc_root;
	logic            prefix_root;
	logic            out_free;
	logic            mem_rd_en;
	logic [CW-1:0]   mem_rd_code;
	logic [CW-1:0]   mem_rd_off;
	logic [NW-1:0]   wr_off;
	logic            stk_rd_en;
	logic [IW-1:0]   stk_rd_addr;

	assign code_ext = CMPW'(code_q);
	assign nfi_ext  = CMPW'(nfi_q);
	assign lim_raw  = CMPW'(dict_limit);

	always_comb begin
		if (lim_raw < CMPW'(BASE_CODES)) begin
			limit = CMPW'(BASE_CODES);
		end else if (lim_raw > CMPW'(DICT_SIZE)) begin
			limit = CMPW'(DICT_SIZE);
		end else begin
			limit = lim_raw;
		end
	end

	assign grow        = have_prev_q && (nfi_ext < limit);
	assign known       = (code_q < CODE_WORD_W'(BASE_CODES)) || (code_ext < nfi_ext);
	assign kwk         = (code_ext == nfi_ext) && grow;
	assign wc          = kwk ? prev_q : code_q[CW-1:0];
	assign wc_root     = (wc < CW'(BASE_CODES));
	assign prefix_root = (rd_prefix_q < CW'(BASE_CODES));
	assign out_free    = !out_valid_q || byte_ready;

	assign status.halted      = halted_q;
	assign status.known       = known;
	assign status.kwk         = kwk;
	assign status.wc_root     = wc_root;
	assign status.prefix_root = prefix_root;
	assign status.room        = (n_q < NCW'(MAX_STRING_LEN));
	assign status.pop_last    = (p_q == '0);
	assign status.out_free    = out_free;

	// dictionary chain read
	assign mem_rd_en   = (cmd.begin_walk && !wc_root) || (cmd.push_tail && !prefix_root);
	assign mem_rd_code = cmd.begin_walk ? wc : rd_prefix_q;
	assign mem_rd_off  = mem_rd_code - CW'(BASE_CODES);
	assign wr_off      = nfi_q - NW'(BASE_CODES);

	always_ff @(posedge clk) begin
		if (mem_rd_en) begin
			rd_prefix_q <= dict_mem[mem_rd_off[AW-1:0]].prefix;
			rd_tail_q   <= dict_mem[mem_rd_off[AW-1:0]].tail;
		end
		if (cmd.push_root && grow) begin
			dict_mem[wr_off[AW-1:0]] <= '{prefix: prev_q, tail: root_q};
		end
	end

	// reverse stack
	assign stk_rd_en   = cmd.stack_rd || (cmd.load_byte && (p_q != '0));
	assign stk_rd_addr = cmd.stack_rd ? p_q : p_q - IW'(1);

	always_ff @(posedge clk) begin
		if (cmd.push_tail) begin
			stack_mem[n_q[IW-1:0]] <= rd_tail_q;
		end else if (cmd.push_root) begin
			stack_mem[n_q[IW-1:0]] <= root_q;
		end
		if (stk_rd_en) begin
			stk_q <= stack_mem[stk_rd_addr];
		end
	end

	// walk bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			code_q <= code_word;
		end
		if (cmd.begin_walk) begin
			n_q   <= kwk ? NCW'(1) : '0;
			kwk_q <= kwk;
			if (wc_root) begin
				root_q <= wc[BYTE_W-1:0];
			end
		end
		if (cmd.push_tail) begin
			n_q <= n_q + NCW'(1);
			if (prefix_root) begin
				root_q <= rd_prefix_q[BYTE_W-1:0];
			end
		end
		if (cmd.push_root) begin
			p_q <= n_q[IW-1:0];
		end
		if (cmd.load_byte && (p_q != '0)) begin
			p_q <= p_q - IW'(1);
		end
	end

	// stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q    <= 1'b0;
			have_prev_q <= 1'b0;
			prev_q      <= '0;
			nfi_q       <= NW'(BASE_CODES);
		end else begin
			if (cmd.accept && stream_start) begin
				halted_q    <= 1'b0;
				have_prev_q <= 1'b0;
				prev_q      <= '0;
				nfi_q       <= NW'(BASE_CODES);
			end
			if (cmd.push_root) begin
				if (grow) begin
					nfi_q <= nfi_q + NW'(1);
				end
				prev_q      <= code_q[CW-1:0];
				have_prev_q <= 1'b1;
			end
			if (cmd.load_err) begin
				halted_q <= 1'b1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_byte || cmd.load_err) begin
			out_valid_q <= 1'b1;
		end else if (byte_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_byte) begin
			out_byte_q <= (kwk_q && (p_q == '0)) ? root_q : stk_q;
			out_last_q <= (p_q == '0);
			out_err_q  <= 1'b0;
		end else if (cmd.load_err) begin
			out_byte_q <= '0;
			out_last_q <= 1'b1;
			out_err_q  <= 1'b1;
		end
	end

	assign byte_valid   = out_valid_q;
	assign data_byte    = out_byte_q;
	assign last_byte    = out_last_q;
	assign decode_error = out_err_q;

endmodule

@@ src/lzwd_ctrl.sv @@
// lzwd_ctrl: sequencing state machine for decode, chain walk and byte emission
// depends on lzwd_pkg; drives lzwd_datapath
module lzwd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   code_valid,
	output logic                   code_ready,
	input  lzwd_pkg::lzwd_status_t status,
	output lzwd_pkg::lzwd_cmd_t    cmd
);
	import lzwd_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECIDE = 7'b0000010,
		S_CHAIN  = 7'b0000100,
		S_ROOT   = 7'b0001000,
		S_RD     = 7'b0010000,
		S_LD     = 7'b0100000,
		S_ERR    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign code_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (code_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (status.halted) begin
					state_d = S_IDLE;
				end else if (status.known || status.kwk) begin
					cmd.begin_walk = 1'b1;
					state_d        = status.wc_root ? S_ROOT : S_CHAIN;
				end else begin
					state_d = S_ERR;
				end
			end
			S_CHAIN: begin
				if (!status.room) begin
					state_d = S_ERR;
				end else begin
					cmd.push_tail = 1'b1;
					state_d       = status.prefix_root ? S_ROOT : S_CHAIN;
				end
			end
			S_ROOT: begin
				if (!status.room) begin
					state_d = S_ERR;
				end else begin
					cmd.push_root = 1'b1;
					state_d       = S_RD;
				end
			end
			S_RD: begin
				cmd.stack_rd = 1'b1;
				state_d      = S_LD;
			end
			S_LD: begin
				if (status.out_free) begin
					cmd.load_byte = 1'b1;
					if (status.pop_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_ERR: begin
				if (status.out_free) begin
					cmd.load_err = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ src/lzw_code_stream_decoder.sv @@
// lzw_code_stream_decoder: top level joining register port, controller and datapath
// depends on lzwd_pkg, lzwd_cfg, lzwd_ctrl, lzwd_datapath
//
//   channel   handshake               payload
//   code      code_valid/code_ready   code_word[15:0], stream_start
//   byte      byte_valid/byte_ready   data_byte[7:0], last_byte, decode_error
//   config    apb psel/penable/pready dict_limit at byte address 0
//
// when a code equals the next free index, its last byte needs no dictionary read
// the chain walk reads one dictionary entry per cycle, then the stack pops one byte
// per cycle while byte_ready is high; an unknown code ends in the error result, a
// code in a halted stream gives no output; a string past the length bound ends in
// the error result once the walk reaches the bound
// async reset clears control state only; dictionary and stack need no clearing pass
// byte_ready low holds the pop; code_ready is high only while no request is in work
module lzw_code_stream_decoder #(
	parameter int DICT_SIZE      = lzwd_pkg::DICT_SIZE_DEF,
	parameter int MAX_STRING_LEN = lzwd_pkg::MAX_STRING_LEN_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lzwd_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [lzwd_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [lzwd_pkg::APB_DATA_W-1:0]  prdata,
	output logic                             pready,
	input  logic                             code_valid,
	output logic                             code_ready,
	input  logic [lzwd_pkg::CODE_WORD_W-1:0] code_word,
	input  logic                             stream_start,
	output logic                             byte_valid,
	input  logic                             byte_ready,
	output logic [lzwd_pkg::BYTE_W-1:0]      data_byte,
	output logic                             last_byte,
	output logic                             decode_error
);
	import lzwd_pkg::*;

	logic [DICT_LIMIT_W-1:0] dict_limit;
	lzwd_cmd_t               cmd;
	lzwd_status_t            status;

	lzwd_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.dict_limit (dict_limit)
	);

	lzwd_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.status     (status),
		.cmd        (cmd)
	);

	lzwd_datapath #(
		.DICT_SIZE      (DICT_SIZE),
		.MAX_STRING_LEN (MAX_STRING_LEN)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.dict_limit   (dict_limit),
		.code_word    (code_word),
		.stream_start (stream_start),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.data_byte    (data_byte),
		.last_byte    (last_byte),
		.decode_error (decode_error)
	);

endmodule
